FILE: rtl/ctp_pkg.sv
package ctp_pkg;

  localparam int MAX_LEN = 64;
  localparam int LCW = 7;
  localparam logic [LCW-1:0] LEN_LIMIT = LCW'(MAX_LEN - 1);

  localparam logic [7:0] CASE_STEP = 8'd32;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_UC_H   = 8'h48;
  localparam logic [7:0] CH_UC_I   = 8'h49;
  localparam logic [7:0] CH_LC_H   = 8'h68;
  localparam logic [7:0] CH_LC_I   = 8'h69;

  localparam int RES_MAX = 3;
  localparam int QDEPTH  = 8;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);
  localparam logic [QCW-1:0] QFILL_MAX = QCW'(QDEPTH - RES_MAX);

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_last;
    logic       error;
  } res_t;

  typedef struct packed {
    logic [1:0]         cnt;
    res_t [RES_MAX-1:0] ent;
  } res_grp_t;

  function automatic logic is_vowel(input logic [7:0] c);
    return c == 8'h41 || c == 8'h45 || c == 8'h49 || c == 8'h59 || c == 8'h4F ||
           c == 8'h55;
  endfunction

  function automatic logic is_hard(input logic [7:0] c);
    return c == 8'h43 || c == 8'h44 || c == 8'h4E || c == 8'h52 || c == 8'h53 ||
           c == 8'h54 || c == 8'h5A;
  endfunction

  function automatic logic is_dnt(input logic [7:0] c);
    return c == 8'h44 || c == 8'h4E || c == 8'h54;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == 8'h20 || c == 8'h2C || c == 8'h2E || c == 8'h21 || c == 8'h3F;
  endfunction

endpackage

FILE: rtl/czech_text_to_phoneme_letters_core.sv
// Czech text to phoneme letters.
// Input channel: one ASCII character per beat (in_ch, in_end_of_string on the
// last character of a string), taken when in_valid is high and in_stall low.
// Output channel: one phoneme letter per beat (out_char, out_is_last,
// out_error), taken when out_valid is high and out_stall low.
// Throughput: one character per cycle while in_stall is low. A character yields
// zero to three beats; up to three come out at the end of a string and drain at
// one beat per cycle while out_stall is low, through an eight-entry queue, so
// in_stall rises only while the queue holds more than five beats.
// A beat is written into the queue at the edge that takes the character
// releasing it and then moves on into the output register; letters lag the
// text by up to two characters for lookahead.
// An error beat has out_char 0, out_is_last and out_error set; the string's
// remaining characters are dropped.
// Reset (rst_n low at a clock edge) clears the lookahead state, empties the
// queue and clears the output valid flag. While out_stall is high the output
// beat holds and the queue fills, then in_stall backs up the input.
module czech_text_to_phoneme_letters_core import ctp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_is_last,
  output logic       out_error
);

  res_grp_t grp;
  logic     full;
  logic     nonempty;
  logic     pop;
  res_t     head;

  assign in_stall = full;

  ctp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_end_of_string(in_end_of_string),
    .grp             (grp)
  );

  ctp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .grp     (grp),
    .pop     (pop),
    .full    (full),
    .nonempty(nonempty),
    .head    (head)
  );

  ctp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nonempty   (nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_is_last(out_is_last),
    .out_error  (out_error)
  );

endmodule

FILE: rtl/ctp_front.sv
module ctp_front import ctp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_string,
  output res_grp_t   grp
);

  logic [7:0]     pend_c_r, pend_c_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [7:0]     held_c_r, held_c_nxt;
  logic           held_v_r, held_v_nxt;
  logic [LCW-1:0] letters_r, letters_nxt;
  logic           disc_r, disc_nxt;

  logic           acc;
  logic [7:0]     conv;
  logic           bad;
  logic [7:0]     p;
  logic           consumed;
  logic           stop;
  logic           clr;
  logic [7:0]     hc;
  logic           hv;
  logic [LCW-1:0] cnt;
  logic           pv;
  logic [1:0]     n;

  assign acc = in_valid && !in_stall;

  always_comb begin
    bad  = 1'b0;
    conv = in_ch;
    if (in_ch >= 8'h61 && in_ch <= 8'h7A) begin
      conv = in_ch - CASE_STEP;
    end else if (!((in_ch >= 8'h41 && in_ch <= 8'h5A) || is_punct(in_ch))) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    grp      = '0;
    n        = 2'd0;
    p        = pend_c_r;
    consumed = 1'b0;
    stop     = 1'b0;
    clr      = 1'b0;
    hc       = held_c_r;
    hv       = held_v_r;
    cnt      = letters_r;
    pv       = pend_v_r;
    pend_c_nxt = pend_c_r;
    disc_nxt   = disc_r;
    if (acc) begin
      if (disc_r) begin
        if (in_end_of_string) begin
          disc_nxt = 1'b0;
          clr      = 1'b1;
        end
      end else begin
        if (pend_v_r) begin
          if (in_ch == CH_APOS) begin
            if (is_vowel(p)) begin
              p        = p + CASE_STEP;
              consumed = 1'b1;
            end
          end else if (in_ch == CH_CARET) begin
            if (is_hard(p)) begin
              p        = p + CASE_STEP;
              consumed = 1'b1;
            end else if (p == CH_UC_E) begin
              if (hv) begin
                hc = hc + CASE_STEP;
              end
              consumed = 1'b1;
            end
          end else if (in_ch == CH_UC_I || in_ch == CH_LC_I) begin
            if (is_dnt(p)) begin
              p = p + CASE_STEP;
            end
          end else if (p == CH_UC_C && (in_ch == CH_UC_H || in_ch == CH_LC_H)) begin
            p        = CH_LC_H;
            consumed = 1'b1;
          end
          if (hv) begin
            grp.ent[n] = '{out_char: hc, is_last: 1'b0, error: 1'b0};
            n = n + 2'd1;
          end
          hc  = p;
          hv  = 1'b1;
          pv  = 1'b0;
          cnt = cnt + LCW'(1);
          if (cnt >= LEN_LIMIT) begin
            grp.ent[n] = '{out_char: p, is_last: 1'b1, error: 1'b0};
            n = n + 2'd1;
            clr      = 1'b1;
            disc_nxt = !in_end_of_string;
            stop     = 1'b1;
          end else if (consumed) begin
            stop = 1'b1;
            if (in_end_of_string) begin
              grp.ent[n] = '{out_char: p, is_last: 1'b1, error: 1'b0};
              n = n + 2'd1;
              clr = 1'b1;
            end
          end
        end
        if (!stop) begin
          if (bad) begin
            grp.ent = '0;
            grp.ent[0] = '{out_char: 8'd0, is_last: 1'b1, error: 1'b1};
            n        = 2'd1;
            clr      = 1'b1;
            disc_nxt = !in_end_of_string;
          end else if (in_end_of_string) begin
            if (hv) begin
              grp.ent[n] = '{out_char: hc, is_last: 1'b0, error: 1'b0};
              n = n + 2'd1;
            end
            grp.ent[n] = '{out_char: conv, is_last: 1'b1, error: 1'b0};
            n   = n + 2'd1;
            clr = 1'b1;
          end else begin
            pend_c_nxt = conv;
            pv         = 1'b1;
          end
        end
      end
    end
    grp.cnt     = n;
    pend_v_nxt  = pv;
    held_c_nxt  = hc;
    held_v_nxt  = hv;
    letters_nxt = cnt;
    if (clr) begin
      pend_c_nxt  = 8'd0;
      pend_v_nxt  = 1'b0;
      held_c_nxt  = 8'd0;
      held_v_nxt  = 1'b0;
      letters_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_c_r  <= 8'd0;
      pend_v_r  <= 1'b0;
      held_c_r  <= 8'd0;
      held_v_r  <= 1'b0;
      letters_r <= '0;
      disc_r    <= 1'b0;
    end else begin
      pend_c_r  <= pend_c_nxt;
      pend_v_r  <= pend_v_nxt;
      held_c_r  <= held_c_nxt;
      held_v_r  <= held_v_nxt;
      letters_r <= letters_nxt;
      disc_r    <= disc_nxt;
    end
  end

endmodule

FILE: rtl/ctp_queue.sv
module ctp_queue import ctp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  res_grp_t grp,
  input  logic     pop,
  output logic     full,
  output logic     nonempty,
  output res_t     head
);

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic [QAW-1:0] widx [RES_MAX];

  assign full     = count_r > QFILL_MAX;
  assign nonempty = count_r != '0;
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    for (int k = 0; k < RES_MAX; k++) begin
      widx[k] = wr_ptr_r + QAW'(k);
    end
    wr_ptr_nxt = wr_ptr_r + QAW'(grp.cnt);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    count_nxt  = count_r + QCW'(grp.cnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (2'(k) < grp.cnt) begin
        mem_r[widx[k]] <= grp.ent[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/ctp_back.sv
module ctp_back import ctp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       nonempty,
  input  res_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_is_last,
  output logic       out_error
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r;
  logic load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && nonempty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = res_r.out_char;
  assign out_is_last = res_r.is_last;
  assign out_error   = res_r.error;

endmodule

FILE: rtl/ctp_checker.sv
module ctp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_is_last,
  input logic       out_error
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_is_last && out_char == 8'd0)
    else $error("error beat without last flag or with nonzero letter");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
    $stable(out_is_last) && $stable(out_error))
    else $error("stalled output beat changed");

  a_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!out_valid) && $past(!in_valid, 2) && $past(!in_valid, 3) &&
    $past(!out_valid, 2) && $past(!out_valid, 3) && $past(rst_n, 3) |-> !out_valid)
    else $error("output beat appeared without input");

endmodule

bind czech_text_to_phoneme_letters_core ctp_checker u_ctp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_char        (out_char),
  .out_is_last     (out_is_last),
  .out_error       (out_error)
);
